>>> src/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants of the two-way cache tag store with LRU ages.
// ----------------------------------------------------------------------------
package tcl_pkg;

    // Geometry (set count and line size are powers of two)
    localparam int SET_COUNT  = 64;
    localparam int LINE_BYTES = 16;
    localparam int ADDR_BITS  = 32;
    localparam int AGE_BITS   = 8;
    localparam int WAYS       = 2;

    localparam int ADDR_W = 32;
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int TAG_W  = ADDR_BITS - OFF_W - $clog2(SET_COUNT);

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    // One way of a set
    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [AGE_BITS-1:0] age;
    } t_way;

    // One memory row holds both ways of a set
    typedef struct packed {
        t_way w1;
        t_way w0;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    // Lookup outcome
    typedef struct packed {
        logic miss;
        logic way;
    } t_result;

    // Control sequencer
    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

>>> src/two_way_cache_tag_lru_top.sv
// ----------------------------------------------------------------------------
// two_way_cache_tag_lru_top
// Tag store of a two-way set-associative cache with counter-based LRU.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+-------------------
//   access   | start high, busy low | i_address
//   result   | o_done, one cycle    | o_miss, o_way
//
// For each item the set row is read from the tag RAM in the cycle after
// acceptance, updated and written back; busy covers that read-modify-write.
// The result strobes in the following cycle, while the next item may
// already be accepted. The receiver cannot stall. Reset clears the per-set
// row valid bits at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_way_cache_tag_lru_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [tcl_pkg::ADDR_W-1:0]   i_address,
    output logic                         busy,
    output logic                         o_done,
    output logic                         o_miss,
    output logic                         o_way
);
    import tcl_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic                 accept;
    logic [SET_W-1:0]     set_in;
    logic [TAG_W-1:0]     tag_in;
    logic [SET_W-1:0]     r_set;
    logic [TAG_W-1:0]     r_tag;
    logic                 r_row_ok;
    logic [SET_COUNT-1:0] r_row_vld;
    logic [ROW_W-1:0]     rd_data;
    t_row                 new_row;
    t_result              res;
    logic                 r_done;
    logic                 r_miss;
    logic                 r_way;
    logic                 wr_en;

    assign accept = start && !busy;

    // Split the address into set and tag
    assign set_in = (SET_COUNT > 1) ? i_address[OFF_W +: SET_W] : '0;
    assign tag_in = i_address[ADDR_BITS-1 -: TAG_W];

    // Next state
    always_comb begin
        case (r_state)
            ST_IDLE:   n_state = accept ? ST_UPDATE : ST_IDLE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        case (r_state)
            ST_IDLE: begin
                busy  = 1'b0;
                wr_en = 1'b0;
            end
            ST_UPDATE: begin
                busy  = 1'b1;
                wr_en = 1'b1;
            end
            default: begin
                busy  = 1'b0;
                wr_en = 1'b0;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the set and tag of the item in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set    <= set_in;
            r_tag    <= tag_in;
            r_row_ok <= r_row_vld[set_in];
        end
    end

    // Mark a set row valid once written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[r_set] <= 1'b1;
        end
    end

    // Tag and age RAM, one row per set
    tcl_ram #(
        .DEPTH (SET_COUNT),
        .WIDTH (ROW_W),
        .AW    (SET_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_set),
        .i_wdata (new_row),
        .i_re    (accept),
        .i_raddr (set_in),
        .o_rdata (rd_data)
    );

    // Update the row read back
    tcl_update u_update (
        .i_row    (t_row'(rd_data)),
        .i_row_ok (r_row_ok),
        .i_tag    (r_tag),
        .o_row    (new_row),
        .o_res    (res)
    );

    // Drive the result strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= wr_en;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_miss <= res.miss;
            r_way  <= res.way;
        end
    end

    assign o_done = r_done;
    assign o_miss = r_miss;
    assign o_way  = r_way;

endmodule

>>> src/tcl_ram.sv
// ----------------------------------------------------------------------------
// tcl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcl_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tcl_update.sv
// ----------------------------------------------------------------------------
// tcl_update
// Tag compare, age update and victim choice for one set.
// ----------------------------------------------------------------------------
module tcl_update (
    input  tcl_pkg::t_row                i_row,
    input  logic                         i_row_ok,
    input  logic [tcl_pkg::TAG_W-1:0]    i_tag,
    output tcl_pkg::t_row                o_row,
    output tcl_pkg::t_result             o_res
);
    import tcl_pkg::*;

    t_row                row;
    logic                hit0;
    logic                hit1;
    logic [AGE_BITS-1:0] age0;
    logic [AGE_BITS-1:0] age1;
    logic                victim;

    // Treat a set never written as all clear
    always_comb begin
        row = i_row_ok ? i_row : '0;
    end

    // Compare tags of valid ways
    assign hit0 = row.w0.valid && (row.w0.tag == i_tag);
    assign hit1 = row.w1.valid && (row.w1.tag == i_tag);

    // Clear the age of a hit way, advance the others up to saturation
    assign age0 = hit0 ? '0 : ((row.w0.age == AGE_MAX) ? row.w0.age : row.w0.age + 1'b1);
    assign age1 = hit1 ? '0 : ((row.w1.age == AGE_MAX) ? row.w1.age : row.w1.age + 1'b1);

    // Pick the older way after ageing, way 0 on a tie
    assign victim = (age0 < age1);

    // Build the row to write back and the result
    always_comb begin
        o_row        = row;
        o_row.w0.age = age0;
        o_row.w1.age = age1;
        o_res.miss   = !(hit0 || hit1);
        o_res.way    = hit0 ? 1'b0 : (hit1 ? 1'b1 : victim);
        if (!(hit0 || hit1)) begin
            if (victim) begin
                o_row.w1.valid = 1'b1;
                o_row.w1.tag   = i_tag;
                o_row.w1.age   = '0;
            end else begin
                o_row.w0.valid = 1'b1;
                o_row.w0.tag   = i_tag;
                o_row.w0.age   = '0;
            end
        end
    end

endmodule

>>> src/tcl_checker.sv
// ----------------------------------------------------------------------------
// tcl_checker
// Port-level checks of the tag store sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module tcl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic                         o_miss,
    input logic                         o_way
);

    // An accepted item holds the block busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    // Every accepted item gives its result once its update state has passed
    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result missing after an accepted item");

    // A result appears only as busy falls, that is for an item in flight
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) && !busy)
        else $error("result without an item in flight");

    // Busy lasts a single cycle
    a_busy_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // A strobed result carries known payload
    a_done_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown({o_miss, o_way}))
        else $error("unknown payload on a strobed result");

endmodule

bind two_way_cache_tag_lru_top tcl_checker u_tcl_checker (.*);
